### rtl/crc_record_deframer_macros.svh
// Assertion macros shared by the record deframer modules.
`ifndef CRC_RECORD_DEFRAMER_MACROS_SVH
`define CRC_RECORD_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define CRD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CRD_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define CRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define CRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/crd_pkg.sv
// Types, constants and the CRC-32C byte function for the record deframer.
`timescale 1ns / 1ps

package crd_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_OK        = 2'd1;
   localparam logic [1:0] KIND_MISMATCH  = 2'd2;
   localparam logic [1:0] KIND_TRUNCATED = 2'd3;

   // CRC-32C, reflected form.
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Event queue between the parser and the result stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One input request.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } req_type;

   // One result.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  record_kind;
      logic [31:0] payload_length;
      logic        last;
   } rsp_type;

   // Everything one input byte produces: an optional payload result followed
   // by an optional verdict or truncation result.
   typedef struct packed {
      logic        has_pay;
      logic        has_tail;
      logic [1:0]  tail_kind;
      logic [7:0]  data_byte;
      logic [7:0]  record_kind;
      logic [31:0] payload_length;
   } event_type;

   // Advance the CRC register by one byte, one bit per step.
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/crd_front.sv
// Record parser: tracks framing and CRC per byte and classifies each byte.
`timescale 1ns / 1ps
`include "crc_record_deframer_macros.svh"

module crd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  crd_pkg::req_type   req_data,
   output logic               ev_push,
   output crd_pkg::event_type ev_data
);
   import crd_pkg::*;

   typedef enum logic [3:0] {
      PH_TYPE = 4'd0,
      PH_LEN0 = 4'd1,
      PH_LEN1 = 4'd2,
      PH_LEN2 = 4'd3,
      PH_LEN3 = 4'd4,
      PH_PAY  = 4'd5,
      PH_CRC0 = 4'd6,
      PH_CRC1 = 4'd7,
      PH_CRC2 = 4'd8,
      PH_CRC3 = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic        halted_ff, halted_in;
   logic        accept;
   logic [7:0]  b;

   assign accept = req_push && !req_full;
   assign b      = req_data.in_byte;

   // Next state and the event for the byte being accepted.
   always_comb begin
      phase_in    = phase_ff;
      cur_type_in = cur_type_ff;
      len_in      = len_ff;
      remain_in   = remain_ff;
      crc_in      = crc_ff;
      rx_crc_in   = rx_crc_ff;
      halted_in   = halted_ff;
      ev_data     = '0;
      if (accept) begin
         if (!halted_ff) begin
            case (phase_ff)
               PH_TYPE: begin
                  cur_type_in = b;
                  len_in      = '0;
                  rx_crc_in   = '0;
                  crc_in      = crc32c_byte(CRC_INIT, b);
                  phase_in    = PH_LEN0;
               end
               PH_LEN0: begin
                  len_in   = len_ff | {24'd0, b};
                  phase_in = PH_LEN1;
               end
               PH_LEN1: begin
                  len_in   = len_ff | {16'd0, b, 8'd0};
                  phase_in = PH_LEN2;
               end
               PH_LEN2: begin
                  len_in   = len_ff | {8'd0, b, 16'd0};
                  phase_in = PH_LEN3;
               end
               PH_LEN3: begin
                  len_in    = len_ff | {b, 24'd0};
                  remain_in = len_in;
                  phase_in  = (len_in != '0) ? PH_PAY : PH_CRC0;
               end
               PH_PAY: begin
                  crc_in            = crc32c_byte(crc_ff, b);
                  remain_in         = remain_ff - 32'd1;
                  ev_data.has_pay   = 1'b1;
                  ev_data.data_byte = b;
                  if (remain_ff == 32'd1) begin
                     phase_in = PH_CRC0;
                  end
               end
               PH_CRC0: begin
                  rx_crc_in = rx_crc_ff | {24'd0, b};
                  phase_in  = PH_CRC1;
               end
               PH_CRC1: begin
                  rx_crc_in = rx_crc_ff | {16'd0, b, 8'd0};
                  phase_in  = PH_CRC2;
               end
               PH_CRC2: begin
                  rx_crc_in = rx_crc_ff | {8'd0, b, 16'd0};
                  phase_in  = PH_CRC3;
               end
               PH_CRC3: begin
                  rx_crc_in        = rx_crc_ff | {b, 24'd0};
                  ev_data.has_tail = 1'b1;
                  if ((crc_ff ^ CRC_INIT) == rx_crc_in) begin
                     ev_data.tail_kind = KIND_OK;
                  end else begin
                     ev_data.tail_kind = KIND_MISMATCH;
                     halted_in         = 1'b1;
                  end
                  phase_in = PH_TYPE;
               end
               default: begin
                  phase_in = PH_TYPE;
               end
            endcase
         end

         // End of file inside an unfinished record reports truncation.
         if (req_data.end_of_file && !halted_in && phase_in != PH_TYPE) begin
            ev_data.has_tail  = 1'b1;
            ev_data.tail_kind = KIND_TRUNCATED;
         end
         ev_data.record_kind    = cur_type_in;
         ev_data.payload_length = len_in;

         // End of file rearms the parser.
         if (req_data.end_of_file) begin
            phase_in    = PH_TYPE;
            cur_type_in = '0;
            len_in      = '0;
            remain_in   = '0;
            crc_in      = CRC_INIT;
            rx_crc_in   = '0;
            halted_in   = 1'b0;
         end
      end
   end

   assign ev_push = accept && (ev_data.has_pay || ev_data.has_tail);

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         cur_type_ff <= '0;
         len_ff      <= '0;
         remain_ff   <= '0;
         crc_ff      <= CRC_INIT;
         rx_crc_ff   <= '0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cur_type_ff <= cur_type_in;
         len_ff      <= len_in;
         remain_ff   <= remain_in;
         crc_ff      <= crc_in;
         rx_crc_ff   <= rx_crc_in;
         halted_ff   <= halted_in;
      end
   end

   // A halted parser always waits at the start of a record.
   `CRD_ASSERT_IMPLIES(a_halt_phase, clock, reset, halted_ff, phase_ff == PH_TYPE, "halted mid-record")
   // After an accepted end of file the parser is rearmed.
   `CRD_ASSERT_NEXT(a_eof_rearm, clock, reset, accept && req_data.end_of_file, !halted_ff && phase_ff == PH_TYPE, "end of file did not rearm")
   // Payload bytes only appear while a payload is still outstanding.
   `CRD_ASSERT_IMPLIES(a_pay_count, clock, reset, accept && phase_ff == PH_PAY && !halted_ff, remain_ff != '0, "payload beyond declared length")

endmodule

### rtl/crd_queue.sv
// Short event queue between the parser and the result stage.
`timescale 1ns / 1ps
`include "crc_record_deframer_macros.svh"

module crd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crd_pkg::event_type push_data,
   output logic               full,
   input  logic               pop,
   output crd_pkg::event_type pop_data,
   output logic               valid
);
   import crd_pkg::*;

   event_type                 store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count never passes the depth.
   `CRD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   // The parser never offers an event while the queue is full.
   `CRD_ASSERT_IMPLIES(a_no_drop, clock, reset, full, !push, "event pushed into full queue")
   // The result stage only pops while an event is waiting.
   `CRD_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, valid, "pop from empty queue")

endmodule

### rtl/crd_back.sv
// Result stage: expands each event into one or two results behind a register.
`timescale 1ns / 1ps
`include "crc_record_deframer_macros.svh"

module crd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  crd_pkg::event_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output crd_pkg::rsp_type   rsp_data
);
   import crd_pkg::*;

   event_type ev_ff, ev_in;
   logic      valid_ff, valid_in;
   logic      second_ff, second_in;
   logic      show_pay;
   logic      taken;
   logic      finishing;

   assign show_pay  = ev_ff.has_pay && !second_ff;
   assign taken     = valid_ff && rsp_pop;
   assign finishing = taken && !(show_pay && ev_ff.has_tail);
   assign q_pop     = q_valid && (!valid_ff || finishing);
   assign rsp_empty = !valid_ff;

   // Present the payload part first, then the verdict or truncation part.
   always_comb begin
      rsp_data.record_kind    = ev_ff.record_kind;
      rsp_data.payload_length = ev_ff.payload_length;
      if (show_pay) begin
         rsp_data.kind      = KIND_PAYLOAD;
         rsp_data.data_byte = ev_ff.data_byte;
         rsp_data.last      = !ev_ff.has_tail;
      end else begin
         rsp_data.kind      = ev_ff.tail_kind;
         rsp_data.data_byte = '0;
         rsp_data.last      = 1'b1;
      end
   end

   // Load the next event once the current one is fully taken.
   always_comb begin
      ev_in     = ev_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (q_pop) begin
         ev_in     = q_data;
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (finishing) begin
         valid_in = 1'b0;
      end else if (taken) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      ev_ff <= ev_in;
   end

   // The second half is only reached for events that carry two results.
   `CRD_ASSERT_IMPLIES(a_second_pair, clock, reset, valid_ff && second_ff, ev_ff.has_pay && ev_ff.has_tail, "second result of single event")
   // Every held event produces at least one result.
   `CRD_ASSERT_IMPLIES(a_nonempty_ev, clock, reset, valid_ff, ev_ff.has_pay || ev_ff.has_tail, "empty event held")
   // A payload result that is not last is followed by its tail result.
   `CRD_ASSERT_NEXT(a_tail_follows, clock, reset, taken && !rsp_data.last, valid_ff && second_ff, "tail result lost")

endmodule

### rtl/crc_record_deframer.sv
// Top level of the CRC-checked record deframer.
//
//   Channel   Ports                          Direction   Accepted when
//   request   req_push, req_full, req_data   in          req_push && !req_full
//   result    rsp_empty, rsp_pop, rsp_data   out         rsp_pop && !rsp_empty
//
// The parser takes one byte per cycle while req_full is low and updates the CRC-32C
// one byte per cycle. Each byte yields zero, one or two results; results leave at one
// per cycle while rsp_pop is high, and two results of one byte are popped in turn.
// A four-entry event queue sits between the parser and the result register.
// req_full rises only when that queue is full. Reset is synchronous and empties
// the queue and the result register.
`timescale 1ns / 1ps

module crc_record_deframer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  crd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output crd_pkg::rsp_type rsp_data
);
   import crd_pkg::*;

   logic      ev_push;
   event_type ev_data;
   logic      q_pop;
   logic      q_valid;
   event_type q_data;

   // Parser.
   crd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .ev_push  (ev_push),
      .ev_data  (ev_data)
   );

   // Event queue.
   crd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .valid     (q_valid)
   );

   // Result stage.
   crd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
